FILE: sv/decimal_digit_display_feeder_defines.svh
// assertion macros for the decimal digit display feeder checker
`ifndef DECIMAL_DIGIT_DISPLAY_FEEDER_DEFINES_SVH
`define DECIMAL_DIGIT_DISPLAY_FEEDER_DEFINES_SVH

// same-cycle implication, disabled while reset is held
`define DDDF_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dddf assertion failed");

// next-cycle implication, disabled while reset is held
`define DDDF_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dddf assertion failed");

`endif

FILE: sv/dddf_pkg.sv
// shared constants and types of the decimal digit display feeder
package dddf_pkg;

    localparam int DIGITS      = 6;
    localparam int VALUE_W     = 16;
    localparam int ADDR_W      = 3;
    localparam int CODE_W      = 4;
    localparam int POS_W       = $clog2(DIGITS + 1);

    localparam logic [CODE_W-1:0] BLANK_CODE = 4'hF;

    // floor(x / 10) == (x * RECIP_10) >> RECIP_SHIFT for every 16-bit x
    localparam logic [VALUE_W-1:0] RECIP_10    = 16'd52429;
    localparam int                 RECIP_SHIFT = 19;
    localparam int                 PROD_W      = 2 * VALUE_W;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [CODE_W-1:0] code;
        logic              last;
    } t_frame;

endpackage

FILE: sv/decimal_digit_display_feeder.sv
// top level: binary value to decimal digit frames with leading zero blanking
//
// Each accepted request is a 16-bit unsigned value; the block sends out six
// display write frames for it, least significant digit first at address 6,
// counting down to the most significant digit at address 1, which carries
// o_last. A digit that is zero with nothing nonzero above it is sent as the
// blank code 15, so a value of zero blanks all six positions, units included.
// The first frame of a value passes the digit stage and then the output
// register. One frame leaves per cycle while the frame side does not stall; a new
// value waits until the last frame of the current one leaves the digit stage,
// as the one result channel carries a single frame per cycle. The next value is
// taken in the same cycle that the last frame of the current one moves into the
// output register. A stalled frame in the output register holds the digit stage
// too, so a stall on the frame side delays the value as well.
module decimal_digit_display_feeder import dddf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // value requests
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [VALUE_W-1:0] i_value,
    // digit frame requests
    output logic               o_valid,
    input  logic               i_stall,
    output logic [ADDR_W-1:0]  o_digit_address,
    output logic [CODE_W-1:0]  o_digit_code,
    output logic               o_last
);

    // digit stage: remaining quotient and position of the next digit
    logic               r_busy;
    logic [VALUE_W-1:0] r_rest;
    logic [POS_W-1:0]   r_pos;
    logic               n_busy;
    logic [VALUE_W-1:0] n_rest;
    logic [POS_W-1:0]   n_pos;

    // output register
    logic   r_out_valid;
    t_frame r_frame;
    logic   n_out_valid;
    t_frame n_frame;

    logic [PROD_W-1:0]  w_prod;
    logic [VALUE_W-1:0] w_quot;
    logic [VALUE_W-1:0] w_rem;
    logic [CODE_W-1:0]  w_code;
    logic               w_out_free;
    logic               w_emit;
    logic               w_last_step;
    logic               w_accept;

    // divide by ten through the reciprocal, remainder by shift and subtract
    always_comb begin
        w_prod = PROD_W'(r_rest) * PROD_W'(RECIP_10);
        w_quot = VALUE_W'(w_prod >> RECIP_SHIFT);
        w_rem  = r_rest - (w_quot << 3) - (w_quot << 1);
        // digit is zero with nothing above it exactly when the rest is zero
        w_code = (r_rest == '0) ? BLANK_CODE : w_rem[CODE_W-1:0];
    end

    // handshake: output slot frees when empty or when its frame is taken
    assign w_out_free  = !r_out_valid || !i_stall;
    assign w_emit      = r_busy && w_out_free;
    assign w_last_step = (r_pos == POS_W'(1));
    assign o_stall     = r_busy && !(w_emit && w_last_step);
    assign w_accept    = i_valid && !o_stall;

    always_comb begin
        n_busy      = r_busy;
        n_rest      = r_rest;
        n_pos       = r_pos;
        n_out_valid = r_out_valid;
        n_frame     = r_frame;
        if (w_emit) begin
            // one digit frame into the output register
            n_out_valid  = 1'b1;
            n_frame.addr = r_pos[ADDR_W-1:0];
            n_frame.code = w_code;
            n_frame.last = w_last_step;
            n_rest       = w_quot;
            n_pos        = r_pos - POS_W'(1);
            if (w_last_step) begin
                n_busy = 1'b0;
            end
        end else if (w_out_free) begin
            n_out_valid = 1'b0;
        end
        // a new value loads when the block is idle or as the previous one finishes
        if (w_accept) begin
            n_busy = 1'b1;
            n_rest = i_value;
            n_pos  = POS_W'(DIGITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        r_rest  <= n_rest;
        r_pos   <= n_pos;
        r_frame <= n_frame;
    end

    assign o_valid         = r_out_valid;
    assign o_digit_address = r_frame.addr;
    assign o_digit_code    = r_frame.code;
    assign o_last          = r_frame.last;

endmodule

FILE: sv/dddf_checker.sv
// port-level checker of the decimal digit display feeder and its bind
`include "decimal_digit_display_feeder_defines.svh"

module dddf_checker import dddf_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic [VALUE_W-1:0] i_value,
    input logic               o_valid,
    input logic               i_stall,
    input logic [ADDR_W-1:0]  o_digit_address,
    input logic [CODE_W-1:0]  o_digit_code,
    input logic               o_last
);

    // a stalled frame holds its payload
    `DDDF_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_digit_address) && $stable(o_digit_code) && $stable(o_last))

    // the last flag marks the most significant position only
    `DDDF_ASSERT_IMP(a_last_addr, i_clk, i_rst_n, o_valid, o_last == (o_digit_address == ADDR_W'(1)))

    // codes are decimal digits or blank
    `DDDF_ASSERT_IMP(a_code_range, i_clk, i_rst_n, o_valid, (o_digit_code <= CODE_W'(9)) || (o_digit_code == BLANK_CODE))

    // frames of one value follow back to back with falling addresses
    `DDDF_ASSERT_NXT(a_addr_step, i_clk, i_rst_n, o_valid && !i_stall && !o_last, o_valid && (o_digit_address == ADDR_W'($past(o_digit_address) - ADDR_W'(1))))

    // a stalled value request holds its value
    `DDDF_ASSERT_NXT(a_in_hold, i_clk, i_rst_n, i_valid && o_stall, i_valid && $stable(i_value))

endmodule

bind decimal_digit_display_feeder dddf_checker u_dddf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .i_value         (i_value),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_digit_address (o_digit_address),
    .o_digit_code    (o_digit_code),
    .o_last          (o_last)
);

FILE: tb/sv/dddf_frame_checker.sv
// frame checker: predicts the digit frames of each value request and compares them
`timescale 1ns / 100ps

module dddf_frame_checker import dddf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_value_valid,
    input  logic               i_value_stall,
    input  logic [VALUE_W-1:0] i_value,
    input  logic               i_frame_valid,
    input  logic               i_frame_stall,
    input  logic [ADDR_W-1:0]  i_frame_addr,
    input  logic [CODE_W-1:0]  i_frame_code,
    input  logic               i_frame_last,
    output int                 o_mismatches,
    output int                 o_frames_due
);

    t_frame frames_due[$];
    int     mismatches = 0;

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    // decimal split, units first, zeros with nothing above them blanked
    function automatic void predict_digit_frames(input logic [VALUE_W-1:0] value);
        int unsigned rest;
        int unsigned digit;
        t_frame      frame;
        rest = value;
        for (int pos = DIGITS; pos > 0; pos--) begin
            digit      = rest % 10;
            rest       = rest / 10;
            frame.addr = ADDR_W'(pos);
            frame.code = (digit == 0 && rest == 0) ? BLANK_CODE : CODE_W'(digit);
            frame.last = (pos == 1);
            frames_due.push_back(frame);
        end
    endfunction

    always @(posedge i_clk) begin
        t_frame want;
        if (i_rst_n) begin
            if (i_value_valid && !i_value_stall) begin
                predict_digit_frames(i_value);
            end
            if (i_frame_valid && !i_frame_stall) begin
                if (frames_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected frame addr %0d code %0d last %0b",
                                              i_frame_addr, i_frame_code, i_frame_last));
                end else begin
                    want = frames_due.pop_front();
                    if (i_frame_addr !== want.addr) begin
                        report_mismatch($sformatf("address %0d, expected %0d",
                                                  i_frame_addr, want.addr));
                    end
                    if (i_frame_code !== want.code) begin
                        report_mismatch($sformatf("code %0d at address %0d, expected %0d",
                                                  i_frame_code, want.addr, want.code));
                    end
                    if (i_frame_last !== want.last) begin
                        report_mismatch($sformatf("last %0b at address %0d, expected %0b",
                                                  i_frame_last, want.addr, want.last));
                    end
                end
            end
        end
        o_frames_due <= frames_due.size();
        o_mismatches <= mismatches;
    end

endmodule

FILE: tb/sv/tb_decimal_digit_display_feeder.sv
// testbench top: value request stimulus, frame stall pattern and the verdict
`timescale 1ns / 100ps

module tb_decimal_digit_display_feeder;
    import dddf_pkg::*;

    localparam int RANDOM_REQUESTS = 400;
    localparam int QUIET_TAIL      = 60;      // last requests run with no idling
    localparam int DRAIN_CYCLES    = 20;
    localparam int CYCLE_LIMIT     = 200000;

    // corner values: zero, single digits, every power of ten boundary,
    // interior zeros, the top of the range and alternating bit patterns
    localparam logic [VALUE_W-1:0] CORNER_VALUES [23] = '{
        16'd0,     16'd1,     16'd9,     16'd10,    16'd11,
        16'd99,    16'd100,   16'd101,   16'd999,   16'd1000,
        16'd1001,  16'd9999,  16'd10000, 16'd10001, 16'd12345,
        16'd54321, 16'd65535, 16'd65534, 16'd65530, 16'd60000,
        16'd32768, 16'h5555,  16'hAAAA
    };

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic [VALUE_W-1:0] i_value = '0;
    logic               i_stall = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic [ADDR_W-1:0]  o_digit_address;
    logic [CODE_W-1:0]  o_digit_code;
    logic               o_last;

    int mismatches;
    int frames_due;
    int cycle_count = 0;
    int stall_left  = 0;
    bit idling_on   = 1'b1;

    always #5 i_clk = ~i_clk;

    decimal_digit_display_feeder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_value         (i_value),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_digit_address (o_digit_address),
        .o_digit_code    (o_digit_code),
        .o_last          (o_last)
    );

    dddf_frame_checker u_frame_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_value_valid (i_valid),
        .i_value_stall (o_stall),
        .i_value       (i_value),
        .i_frame_valid (o_valid),
        .i_frame_stall (i_stall),
        .i_frame_addr  (o_digit_address),
        .i_frame_code  (o_digit_code),
        .i_frame_last  (o_last),
        .o_mismatches  (mismatches),
        .o_frames_due  (frames_due)
    );

    // run limit, well above the slowest correct run of all requests
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // frame side stall: random bursts while idling is allowed
    always @(posedge i_clk) begin
        if (!i_rst_n || !idling_on) begin
            i_stall    <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 1) begin
            stall_left <= stall_left - 1;
        end else if (stall_left == 1) begin
            stall_left <= 0;
            i_stall    <= 1'b0;
        end else if ($urandom_range(0, 3) == 0) begin
            stall_left <= $urandom_range(1, 5);
            i_stall    <= 1'b1;
        end
    end

    // one value request; valid stays high into the next request unless a gap is taken
    task automatic send_value(input logic [VALUE_W-1:0] value);
        i_valid <= 1'b1;
        i_value <= value;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (idling_on && $urandom_range(0, 2) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    // random values weighted towards short numbers and decade boundaries,
    // where the leading zero blanking has the most to do
    function automatic logic [VALUE_W-1:0] pick_value();
        int unsigned decade;
        case ($urandom_range(0, 5))
            0:    pick_value = VALUE_W'($urandom_range(0, 65535));
            1:    pick_value = VALUE_W'($urandom_range(0, 65535));
            2:    pick_value = VALUE_W'($urandom_range(0, 99));
            3:    pick_value = VALUE_W'($urandom_range(0, 9999));
            4: begin
                case ($urandom_range(0, 4))
                    0:       decade = 1;
                    1:       decade = 10;
                    2:       decade = 100;
                    3:       decade = 1000;
                    default: decade = 10000;
                endcase
                // a single nonzero digit, or one either side of it
                pick_value = VALUE_W'(decade * $urandom_range(1, 6) + $urandom_range(0, 2) - 1);
            end
            default: pick_value = VALUE_W'(65535 - $urandom_range(0, 600));
        endcase
    endfunction

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (CORNER_VALUES[n]) begin
            send_value(CORNER_VALUES[n]);
        end

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            // stretches without idling, and none at all in the tail
            idling_on = (n < RANDOM_REQUESTS - QUIET_TAIL) && ((n / 50) % 4 != 3);
            send_value(pick_value());
        end
        i_valid <= 1'b0;

        // wait for every predicted frame, then drain for strays
        while (frames_due != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
